// ===== src/urb_pkg.sv =====
`default_nettype none

package urb_pkg;

  // Default ring size in bytes (one slot always kept free)
  localparam int unsigned RING_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    OP_CPU_READ   = 2'd0,
    OP_CPU_WRITE  = 2'd1,
    OP_LINE_RX    = 2'd2,
    OP_LINE_READY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

endpackage

`default_nettype wire

// ===== src/urb_if.sv =====
`default_nettype none

// Event channel: one beat is one CPU or line event
interface urb_req_if import urb_pkg::*; ();
  logic       valid;
  logic       ready;
  op_t        operation;
  logic [7:0] data_in;

  modport source (output valid, operation, data_in, input ready);
  modport sink   (input valid, operation, data_in, output ready);
endinterface

// Result channel: one beat per event
interface urb_rsp_if import urb_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  logic [7:0] data_out;
  logic       line_send;
  logic       rx_irq_enable;
  logic       tx_irq_enable;

  modport source (output valid, status, data_out, line_send, rx_irq_enable,
                  tx_irq_enable, input ready);
  modport sink   (input valid, status, data_out, line_send, rx_irq_enable,
                  tx_irq_enable, output ready);
endinterface

`default_nettype wire

// ===== src/urb_ring_ram.sv =====
`default_nettype none

// Byte ring storage: one write port, one registered read port
module urb_ring_ram import urb_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/uart_rx_tx_ring_buffers.sv =====
`default_nettype none

// An accepted event beat is registered in the read stage, then in the output
// register. One event per cycle while the result channel takes beats; the ring read
// is issued at accept and each ring memory's registered read port delivers the byte
// in the next cycle. Reset clears the ring pointers, both interrupt enables and the
// pipeline valids; ring contents are not cleared and are never read unwritten.
module uart_rx_tx_ring_buffers import urb_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  urb_req_if.sink    req,
  urb_rsp_if.source  rsp
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);

  // Pointers and enables
  logic [AW-1:0] rx_head, rx_tail, tx_head, tx_tail;
  logic [AW-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
  logic          rx_ie, tx_ie, rx_ie_next, tx_ie_next;

  // Read stage
  logic    s1_valid;
  status_t s1_status;
  logic    s1_rd_rx, s1_rd_tx;
  logic    s1_rx_ie, s1_tx_ie;

  // Ring ports
  logic       rx_we, rx_re, tx_we, tx_re;
  logic [7:0] rx_wdata, rx_rdata, tx_rdata;

  logic    accept, advance;
  logic    rx_empty, rx_full, tx_empty, tx_full;
  status_t status_c;

  assign rx_head_inc = (rx_head == PTR_LAST) ? '0 : rx_head + 1'b1;
  assign rx_tail_inc = (rx_tail == PTR_LAST) ? '0 : rx_tail + 1'b1;
  assign tx_head_inc = (tx_head == PTR_LAST) ? '0 : tx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == PTR_LAST) ? '0 : tx_tail + 1'b1;

  assign rx_empty = (rx_head == rx_tail);
  assign rx_full  = (rx_head_inc == rx_tail);
  assign tx_empty = (tx_head == tx_tail);
  assign tx_full  = (tx_head_inc == tx_tail);

  // Read stage moves on when the output register is free or being drained
  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;

  assign rx_wdata = (req.data_in == CHAR_CR) ? CHAR_LF : req.data_in;

  // Event decode
  always_comb begin
    status_c   = ST_DONE;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    rx_ie_next = rx_ie;
    tx_ie_next = tx_ie;
    unique case (req.operation)
      OP_CPU_READ: begin
        rx_ie_next = 1'b1;
        if (rx_empty) begin
          status_c = ST_EMPTY;
        end else begin
          rx_re = accept;
        end
      end
      OP_CPU_WRITE: begin
        tx_ie_next = 1'b1;
        if (tx_full) begin
          status_c = ST_FULL;
        end else begin
          tx_we = accept;
        end
      end
      OP_LINE_RX: begin
        if (rx_full) begin
          status_c   = ST_FULL;
          rx_ie_next = 1'b0;
        end else begin
          rx_we      = accept;
          rx_ie_next = 1'b1;
        end
      end
      OP_LINE_READY: begin
        if (tx_empty) begin
          status_c   = ST_EMPTY;
          tx_ie_next = 1'b0;
        end else begin
          tx_re      = accept;
          tx_ie_next = 1'b1;
        end
      end
      default: begin
        status_c = ST_DONE;
      end
    endcase
  end

  urb_ring_ram #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head),
    .wdata (rx_wdata),
    .re    (rx_re),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  urb_ring_ram #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head),
    .wdata (req.data_in),
    .re    (tx_re),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  // Pointer and enable state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head <= '0;
      rx_tail <= '0;
      tx_head <= '0;
      tx_tail <= '0;
      rx_ie   <= 1'b0;
      tx_ie   <= 1'b0;
    end else if (accept) begin
      if (rx_we) rx_head <= rx_head_inc;
      if (rx_re) rx_tail <= rx_tail_inc;
      if (tx_we) tx_head <= tx_head_inc;
      if (tx_re) tx_tail <= tx_tail_inc;
      rx_ie <= rx_ie_next;
      tx_ie <= tx_ie_next;
    end
  end

  // Read stage: waits for ring read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_c;
      s1_rd_rx  <= rx_re;
      s1_rd_tx  <= tx_re;
      s1_rx_ie  <= rx_ie_next;
      s1_tx_ie  <= tx_ie_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status        <= s1_status;
      rsp.line_send     <= s1_rd_tx;
      rsp.data_out      <= s1_rd_rx ? rx_rdata : (s1_rd_tx ? tx_rdata : 8'h00);
      rsp.rx_irq_enable <= s1_rx_ie;
      rsp.tx_irq_enable <= s1_tx_ie;
    end
  end

  ap_rx_store_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && rx_we) |=> (rx_head != rx_tail))
    else $error("rx ring empty right after a stored byte");

  ap_tx_store_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && tx_we) |=> (tx_head != tx_tail))
    else $error("tx ring empty right after a stored byte");

  ap_single_ring_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1_rd_rx && s1_rd_tx))
    else $error("both rings read for one event");

  ap_send_is_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.line_send) |-> (rsp.status == ST_DONE))
    else $error("line send with a non-done status");

  ap_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_status)))
    else $error("read stage lost a stalled event");

endmodule

`default_nettype wire
